// ===== rtl/core/akf_pkg.sv =====
// ============================================================================
// akf_pkg
// Types, codes and saturating Q16.16 helpers for the angle and gyro bias
// Kalman filter.
// ============================================================================
package akf_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned PROD_W   = 2 * DATA_W;
    localparam int unsigned DIV_W    = DATA_W + 16;
    localparam int unsigned DIV_STEP = 2;
    localparam int unsigned DIV_CYCLES = DIV_W / DIV_STEP;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_CYCLES);

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

    localparam logic [CFG_W-1:0] RST_ANGLE_NOISE   = 16'd1638;
    localparam logic [CFG_W-1:0] RST_BIAS_NOISE    = 16'd1114;
    localparam logic [CFG_W-1:0] RST_MEASURE_NOISE = 16'd1638;
    localparam logic [CFG_W-1:0] RST_TIME_STEP     = 16'd3932;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 8'd3;

    typedef logic [3:0] t_op;

    localparam t_op OP_ANGLE_PRED = 4'd0;
    localparam t_op OP_P00_PRED   = 4'd1;
    localparam t_op OP_CROSS_PRED = 4'd2;
    localparam t_op OP_P11_PRED   = 4'd3;
    localparam t_op OP_P10_CORR   = 4'd4;
    localparam t_op OP_P00_CORR   = 4'd5;
    localparam t_op OP_P11_CORR   = 4'd6;
    localparam t_op OP_P01_CORR   = 4'd7;
    localparam t_op OP_ANGLE_CORR = 4'd8;
    localparam t_op OP_BIAS_CORR  = 4'd9;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_RND,
        S_ACC,
        S_ERR,
        S_DLOAD,
        S_DITER,
        S_DDONE,
        S_OUT
    } t_state;

    function automatic logic signed [DATA_W-1:0] f_sat(input logic signed [DATA_W+1:0] v);
        if (!v[DATA_W+1] && (v[DATA_W:DATA_W-1] != 2'b00)) begin
            return Q_MAX;
        end else if (v[DATA_W+1] && (v[DATA_W:DATA_W-1] != 2'b11)) begin
            return Q_MIN;
        end else begin
            return v[DATA_W-1:0];
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] f_add(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
        return f_sat(34'(a) + 34'(b));
    endfunction

    function automatic logic signed [DATA_W-1:0] f_sub(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
        return f_sat(34'(a) - 34'(b));
    endfunction

    // Rounds a full product to nearest with ties upward, then saturates.
    function automatic logic signed [DATA_W-1:0] f_round(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + 64'sd32768;
        if (!s[PROD_W-1] && (s[PROD_W-2:47] != '0)) begin
            return Q_MAX;
        end else if (s[PROD_W-1] && (s[PROD_W-2:47] != '1)) begin
            return Q_MIN;
        end else begin
            return s[47:16];
        end
    endfunction

endpackage

// ===== rtl/core/angle_gyro_kalman_filter.sv =====
// ============================================================================
// angle_gyro_kalman_filter
// Each request carries one accelerometer angle and one gyro rate in signed
// Q16.16 and yields one result with the filtered angle and the bias-corrected
// rate. From acceptance until its result is loaded into the output register
// the block accepts no new request. The work is done by one shared 32x32
// multiplier, used ten times, each use a multiply, a round and an accumulate
// step, plus a preparation step before each of the first three uses, and by
// one restoring divider that retires two quotient bits per cycle and runs
// twice over 48 bits for the two gains, with a load and a finish step each.
// One more step forms the innovation and one loads the output register. A
// finished result waits in an output register, so the next request is
// accepted while the previous result is still pending. Configuration writes
// take effect at once and are meant to happen only while idle.
// ============================================================================
module angle_gyro_kalman_filter
    import akf_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_addr,
    input  logic [CFG_W-1:0]            i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [DATA_W-1:0]    i_measured_angle,
    input  logic signed [DATA_W-1:0]    i_measured_rate,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [DATA_W-1:0]    o_filtered_angle,
    output logic signed [DATA_W-1:0]    o_corrected_rate
);

    t_state r_state, n_state;
    t_op    r_op, n_op;

    logic [CFG_W-1:0] r_qa, r_qb, r_r, r_dt;

    logic signed [DATA_W-1:0] r_angle, n_angle;
    logic signed [DATA_W-1:0] r_bias, n_bias;
    logic signed [DATA_W-1:0] r_p00, n_p00;
    logic signed [DATA_W-1:0] r_p01, n_p01;
    logic signed [DATA_W-1:0] r_p10, n_p10;
    logic signed [DATA_W-1:0] r_p11, n_p11;

    logic signed [DATA_W-1:0] r_z, n_z;
    logic signed [DATA_W-1:0] r_w, n_w;
    logic signed [DATA_W-1:0] r_t, n_t;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [DATA_W-1:0] r_q, n_q;
    logic signed [DATA_W-1:0] r_err, n_err;
    logic signed [DATA_W-1:0] r_e, n_e;
    logic signed [DATA_W-1:0] r_k0, n_k0;
    logic signed [DATA_W-1:0] r_k1, n_k1;

    logic                 r_dsel, n_dsel;
    logic                 r_dneg, n_dneg;
    logic                 r_dzero, n_dzero;
    logic [DATA_W-1:0]    r_dden, n_dden;
    logic [DATA_W-1:0]    r_rem, n_rem;
    logic [DIV_W-1:0]     r_quo, n_quo;
    logic [DIV_CNT_W-1:0] r_dcnt, n_dcnt;

    logic                     r_out_valid, n_out_valid;
    logic signed [DATA_W-1:0] r_out_angle, n_out_angle;
    logic signed [DATA_W-1:0] r_out_rate, n_out_rate;

    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [DATA_W-1:0] dt_q, qb_q, qa_q, r_q16;

    assign dt_q  = $signed({16'd0, r_dt});
    assign qb_q  = $signed({16'd0, r_qb});
    assign qa_q  = $signed({16'd0, r_qa});
    assign r_q16 = $signed({16'd0, r_r});

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_filtered_angle = r_out_angle;
    assign o_corrected_rate = r_out_rate;

    always_comb begin
        case (r_op)
            OP_ANGLE_PRED, OP_P00_PRED, OP_CROSS_PRED: begin
                mul_a = r_t;
                mul_b = dt_q;
            end
            OP_P11_PRED: begin
                mul_a = qb_q;
                mul_b = dt_q;
            end
            OP_P10_CORR: begin
                mul_a = r_k1;
                mul_b = r_p00;
            end
            OP_P00_CORR: begin
                mul_a = r_k0;
                mul_b = r_p00;
            end
            OP_P11_CORR: begin
                mul_a = r_k1;
                mul_b = r_p01;
            end
            OP_P01_CORR: begin
                mul_a = r_k0;
                mul_b = r_p01;
            end
            OP_ANGLE_CORR: begin
                mul_a = r_k0;
                mul_b = r_err;
            end
            OP_BIAS_CORR: begin
                mul_a = r_k1;
                mul_b = r_err;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        logic [DATA_W:0]          trial;
        logic [DATA_W-1:0]        rem;
        logic [DIV_W-1:0]         quo;
        logic signed [DATA_W-1:0] num;
        logic [DATA_W-1:0]        num_abs;
        logic [DIV_W-1:0]         mag;
        logic signed [DATA_W-1:0] kval;

        n_state     = r_state;
        n_op        = r_op;
        n_angle     = r_angle;
        n_bias      = r_bias;
        n_p00       = r_p00;
        n_p01       = r_p01;
        n_p10       = r_p10;
        n_p11       = r_p11;
        n_z         = r_z;
        n_w         = r_w;
        n_t         = r_t;
        n_prod      = r_prod;
        n_q         = r_q;
        n_err       = r_err;
        n_e         = r_e;
        n_k0        = r_k0;
        n_k1        = r_k1;
        n_dsel      = r_dsel;
        n_dneg      = r_dneg;
        n_dzero     = r_dzero;
        n_dden      = r_dden;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dcnt      = r_dcnt;
        n_out_valid = r_out_valid;
        n_out_angle = r_out_angle;
        n_out_rate  = r_out_rate;

        rem     = r_rem;
        quo     = r_quo;
        trial   = '0;
        num     = r_dsel ? r_p10 : r_p00;
        num_abs = num[DATA_W-1] ? (~num + 32'd1) : num;
        mag     = r_quo;
        kval    = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_z     = i_measured_angle;
                    n_w     = i_measured_rate;
                    n_op    = OP_ANGLE_PRED;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                case (r_op)
                    OP_ANGLE_PRED: n_t = f_sub(r_w, r_bias);
                    OP_P00_PRED:   n_t = f_sat(34'(qa_q) - 34'(r_p01) - 34'(r_p10));
                    OP_CROSS_PRED: n_t = f_sub('0, r_p11);
                    default:       n_t = r_t;
                endcase
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = mul_a * mul_b;
                n_state = S_RND;
            end
            S_RND: begin
                n_q     = f_round(r_prod);
                n_state = S_ACC;
            end
            S_ACC: begin
                case (r_op)
                    OP_ANGLE_PRED: n_angle = f_add(r_angle, r_q);
                    OP_P00_PRED:   n_p00 = f_add(r_p00, r_q);
                    OP_CROSS_PRED: begin
                        n_p01 = f_add(r_p01, r_q);
                        n_p10 = f_add(r_p10, r_q);
                    end
                    OP_P11_PRED:   n_p11 = f_add(r_p11, r_q);
                    OP_P10_CORR:   n_p10 = f_sub(r_p10, r_q);
                    OP_P00_CORR:   n_p00 = f_sub(r_p00, r_q);
                    OP_P11_CORR:   n_p11 = f_sub(r_p11, r_q);
                    OP_P01_CORR:   n_p01 = f_sub(r_p01, r_q);
                    OP_ANGLE_CORR: n_angle = f_add(r_angle, r_q);
                    OP_BIAS_CORR:  n_bias = f_add(r_bias, r_q);
                    default:       n_angle = r_angle;
                endcase
                n_op = r_op + 4'd1;
                if (r_op == OP_P11_PRED) begin
                    n_state = S_ERR;
                end else if (r_op == OP_BIAS_CORR) begin
                    n_state = S_OUT;
                end else if (r_op == OP_ANGLE_PRED || r_op == OP_P00_PRED) begin
                    n_state = S_PREP;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_ERR: begin
                n_err   = f_sub(r_z, r_angle);
                n_e     = f_add(r_q16, r_p00);
                n_dsel  = 1'b0;
                n_state = S_DLOAD;
            end
            S_DLOAD: begin
                n_quo   = {num_abs, 16'd0};
                n_rem   = '0;
                n_dcnt  = '0;
                n_dneg  = num[DATA_W-1] ^ r_e[DATA_W-1];
                n_dzero = (r_e == '0);
                n_dden  = r_e[DATA_W-1] ? (~r_e + 32'd1) : r_e;
                n_state = S_DITER;
            end
            S_DITER: begin
                for (int i = 0; i < DIV_STEP; i++) begin
                    trial = {rem, quo[DIV_W-1]};
                    if (trial >= {1'b0, r_dden}) begin
                        trial = trial - {1'b0, r_dden};
                        quo   = {quo[DIV_W-2:0], 1'b1};
                    end else begin
                        quo   = {quo[DIV_W-2:0], 1'b0};
                    end
                    rem = trial[DATA_W-1:0];
                end
                n_rem  = rem;
                n_quo  = quo;
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    n_state = S_DDONE;
                end
            end
            S_DDONE: begin
                if (r_dzero) begin
                    kval = '0;
                end else if (!r_dneg) begin
                    kval = (mag[DIV_W-1:DATA_W-1] != '0) ? Q_MAX : $signed(mag[DATA_W-1:0]);
                end else if ((mag[DIV_W-1:DATA_W] != '0)
                             || (mag[DATA_W-1] && (mag[DATA_W-2:0] != '0))) begin
                    kval = Q_MIN;
                end else begin
                    kval = $signed(~mag[DATA_W-1:0] + 32'd1);
                end
                if (!r_dsel) begin
                    n_k0    = kval;
                    n_dsel  = 1'b1;
                    n_state = S_DLOAD;
                end else begin
                    n_k1    = kval;
                    n_op    = OP_P10_CORR;
                    n_state = S_MUL;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_angle = r_angle;
                    n_out_rate  = f_sub(r_w, r_bias);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_ANGLE_PRED;
            r_out_valid <= 1'b0;
            r_angle     <= '0;
            r_bias      <= '0;
            r_p00       <= Q_ONE;
            r_p01       <= '0;
            r_p10       <= '0;
            r_p11       <= Q_ONE;
            r_dsel      <= 1'b0;
            r_dcnt      <= '0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_out_valid <= n_out_valid;
            r_angle     <= n_angle;
            r_bias      <= n_bias;
            r_p00       <= n_p00;
            r_p01       <= n_p01;
            r_p10       <= n_p10;
            r_p11       <= n_p11;
            r_dsel      <= n_dsel;
            r_dcnt      <= n_dcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= RST_ANGLE_NOISE;
            r_qb <= RST_BIAS_NOISE;
            r_r  <= RST_MEASURE_NOISE;
            r_dt <= RST_TIME_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_ANGLE_NOISE:   r_qa <= i_cfg_data;
                REG_BIAS_NOISE:    r_qb <= i_cfg_data;
                REG_MEASURE_NOISE: r_r  <= i_cfg_data;
                REG_TIME_STEP:     r_dt <= i_cfg_data;
                default:           r_dt <= r_dt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_z         <= n_z;
        r_w         <= n_w;
        r_t         <= n_t;
        r_prod      <= n_prod;
        r_q         <= n_q;
        r_err       <= n_err;
        r_e         <= n_e;
        r_k0        <= n_k0;
        r_k1        <= n_k1;
        r_dneg      <= n_dneg;
        r_dzero     <= n_dzero;
        r_dden      <= n_dden;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_out_angle <= n_out_angle;
        r_out_rate  <= n_out_rate;
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("Block still ready right after accepting a request.");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("Result became valid outside the output state.");

    a_div_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DITER) |-> (r_dcnt <= DIV_CNT_W'(DIV_CYCLES - 1)))
        else $error("Divider step count out of range.");

    a_op_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_op <= OP_BIAS_CORR))
        else $error("Multiply issued with an undefined operation code.");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking testbench for the angle and gyro bias Kalman filter. A queue
// of pending samples feeds a bursty request driver, and a monitor compares
// every result against a bit-exact Q16.16 model of the filter that it keeps
// in step with each accepted request. The run goes through directed corner
// samples and several register settings, extremes included, and then through
// random phases that mix smooth sensor tracks with full-range values.
// ============================================================================
module tb_top;
    import akf_pkg::*;

    typedef logic signed [DATA_W-1:0] q16_t;
    typedef struct packed { q16_t angle; q16_t rate; } kf_sample_t;
    typedef struct packed { q16_t angle; q16_t rate; } kf_result_t;

    localparam int unsigned QUIET_LIMIT   = 20000;
    localparam int unsigned RANDOM_PHASES = 7;
    localparam int unsigned PHASE_SAMPLES = 250;
    localparam int unsigned TAIL_CYCLES   = 120;
    localparam int          TRACK_LIMIT   = 5898240;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    q16_t                 i_measured_angle = '0;
    q16_t                 i_measured_rate = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    q16_t                 o_filtered_angle;
    q16_t                 o_corrected_rate;

    logic [CFG_W-1:0] cfg_angle_noise = RST_ANGLE_NOISE;
    logic [CFG_W-1:0] cfg_bias_noise = RST_BIAS_NOISE;
    logic [CFG_W-1:0] cfg_measure_noise = RST_MEASURE_NOISE;
    logic [CFG_W-1:0] cfg_time_step = RST_TIME_STEP;
    q16_t             est_angle = '0;
    q16_t             est_bias = '0;
    q16_t             cov [4] = '{Q_ONE, '0, '0, Q_ONE};

    kf_sample_t  pending_samples [$];
    kf_result_t  expected_outputs [$];

    logic        in_fire = 1'b0;
    logic        drain_wait = 1'b0;
    int unsigned gap_left = 0;
    int unsigned burst_left = 0;
    int unsigned burst_count = 0;
    logic [15:0] ready_pat = 16'hFFFF;
    int unsigned pat_age = 0;
    int unsigned mismatch_count = 0;
    int unsigned result_count = 0;
    int unsigned quiet_cycles = 0;
    int          track_angle = 0;
    int          rate_offset = 0;

    angle_gyro_kalman_filter DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_measured_angle (i_measured_angle),
        .i_measured_rate  (i_measured_rate),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_filtered_angle (o_filtered_angle),
        .o_corrected_rate (o_corrected_rate)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic q16_t clamp_q(input longint v);
        if (v > longint'(Q_MAX)) return Q_MAX;
        if (v < longint'(Q_MIN)) return Q_MIN;
        return q16_t'(v);
    endfunction

    function automatic q16_t sat_add(input q16_t a, input q16_t b);
        return clamp_q(longint'(a) + longint'(b));
    endfunction

    function automatic q16_t sat_sub(input q16_t a, input q16_t b);
        return clamp_q(longint'(a) - longint'(b));
    endfunction

    function automatic q16_t fx_mul(input q16_t a, input q16_t b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return clamp_q((prod + 64'sd32768) >>> 16);
    endfunction

    function automatic q16_t fx_div(input q16_t num, input q16_t den);
        if (den == '0) return '0;
        return clamp_q((longint'(num) * 64'sd65536) / longint'(den));
    endfunction

    task automatic kf_advance(input q16_t z, input q16_t w);
        q16_t       dt, qa, qb, rn;
        q16_t       p00, p01, p10, p11, d0, innov, var_e, k0, k1;
        kf_result_t res;
        dt = q16_t'({16'd0, cfg_time_step});
        qa = q16_t'({16'd0, cfg_angle_noise});
        qb = q16_t'({16'd0, cfg_bias_noise});
        rn = q16_t'({16'd0, cfg_measure_noise});

        est_angle = sat_add(est_angle, fx_mul(sat_sub(w, est_bias), dt));
        p00 = cov[0];
        p01 = cov[1];
        p10 = cov[2];
        p11 = cov[3];
        d0  = clamp_q(longint'(qa) - longint'(p01) - longint'(p10));
        p00 = sat_add(p00, fx_mul(d0, dt));
        p01 = sat_add(p01, fx_mul(sat_sub('0, p11), dt));
        p10 = sat_add(p10, fx_mul(sat_sub('0, p11), dt));
        p11 = sat_add(p11, fx_mul(qb, dt));

        innov = sat_sub(z, est_angle);
        var_e = sat_add(rn, p00);
        k0    = fx_div(p00, var_e);
        k1    = fx_div(p10, var_e);

        cov[0]    = sat_sub(p00, fx_mul(k0, p00));
        cov[1]    = sat_sub(p01, fx_mul(k0, p01));
        cov[2]    = sat_sub(p10, fx_mul(k1, p00));
        cov[3]    = sat_sub(p11, fx_mul(k1, p01));
        est_angle = sat_add(est_angle, fx_mul(k0, innov));
        est_bias  = sat_add(est_bias, fx_mul(k1, innov));

        res.angle = est_angle;
        res.rate  = sat_sub(w, est_bias);
        expected_outputs.push_back(res);
    endtask

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic queue_sample(input q16_t a, input q16_t r);
        kf_sample_t s;
        s.angle = a;
        s.rate  = r;
        pending_samples.push_back(s);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_ANGLE_NOISE:   cfg_angle_noise = val;
            REG_BIAS_NOISE:    cfg_bias_noise = val;
            REG_MEASURE_NOISE: cfg_measure_noise = val;
            REG_TIME_STEP:     cfg_time_step = val;
            default: ;
        endcase
    endtask

    // Writes beyond the last register must leave the settings unchanged.
    task automatic load_settings(input logic [CFG_W-1:0] qa, input logic [CFG_W-1:0] qb,
                                 input logic [CFG_W-1:0] rn, input logic [CFG_W-1:0] dt,
                                 input int unsigned junk_writes);
        write_reg(REG_ANGLE_NOISE, qa);
        write_reg(REG_BIAS_NOISE, qb);
        write_reg(REG_MEASURE_NOISE, rn);
        write_reg(REG_TIME_STEP, dt);
        for (int unsigned i = 0; i < junk_writes; i++) begin
            case (i)
                0:       write_reg(REG_TIME_STEP + 1'b1, 16'($urandom));
                1:       write_reg('1, 16'($urandom));
                default: write_reg(CFG_IDX_W'($urandom_range(4, 255)), 16'($urandom));
            endcase
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_samples.size() != 0 || i_in_valid || expected_outputs.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_setting();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return CFG_W'($urandom_range(0, 4096));
            default: return CFG_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic kf_sample_t draw_sample();
        kf_sample_t s;
        q16_t       corner [7] = '{Q_MAX, Q_MIN, '0, 32'sd1, -32'sd1, Q_ONE, -Q_ONE};
        track_angle += int'($urandom_range(0, 4000)) - 2000;
        if (track_angle > TRACK_LIMIT) track_angle = TRACK_LIMIT;
        if (track_angle < -TRACK_LIMIT) track_angle = -TRACK_LIMIT;
        case ($urandom_range(0, 9))
            6: begin
                s.angle = $urandom;
                s.rate  = $urandom;
            end
            7: begin
                s.angle = corner[$urandom_range(0, 6)];
                s.rate  = corner[$urandom_range(0, 6)];
            end
            8: begin
                s.angle = q16_t'($urandom) >>> $urandom_range(0, 31);
                s.rate  = q16_t'($urandom) >>> $urandom_range(0, 31);
            end
            9: begin
                s.angle = $urandom;
                s.rate  = rate_offset + int'($urandom_range(0, 20000)) - 10000;
            end
            default: begin
                s.angle = track_angle + int'($urandom_range(0, 6000)) - 3000;
                s.rate  = rate_offset + int'($urandom_range(0, 20000)) - 10000;
            end
        endcase
        return s;
    endfunction

    always @(negedge i_clk) begin : drive_requests
        kf_sample_t s;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_fire) begin
            if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (drain_wait) begin
                drain_wait = (expected_outputs.size() != 0);
                i_in_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                s = pending_samples.pop_front();
                i_measured_angle <= s.angle;
                i_measured_rate  <= s.rate;
                i_in_valid       <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    burst_count++;
                    drain_wait = (burst_count % 16 == 0);
                    case ($urandom_range(0, 7))
                        0, 1:    gap_left = 0;
                        2:       gap_left = $urandom_range(60, 150);
                        default: gap_left = $urandom_range(1, 12);
                    endcase
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (pat_age == 0) begin
            case ($urandom_range(0, 3))
                0:       ready_pat = '1;
                1:       ready_pat = 16'h8000 >> $urandom_range(0, 15);
                default: ready_pat = 16'($urandom) | 16'h0001;
            endcase
            pat_age = $urandom_range(50, 600);
        end else begin
            pat_age--;
        end
        i_out_ready <= ready_pat[0];
        ready_pat = {ready_pat[0], ready_pat[15:1]};
    end

    always @(posedge i_clk) begin : check_results
        kf_result_t want;
        in_fire <= i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_outputs.size() == 0) begin
                log_mismatch($sformatf("result %0d arrived with no request pending",
                                       result_count));
            end else begin
                want = expected_outputs.pop_front();
                if (o_filtered_angle !== want.angle) begin
                    log_mismatch($sformatf("result %0d filtered_angle got %0d expected %0d",
                                           result_count, o_filtered_angle, want.angle));
                end
                if (o_corrected_rate !== want.rate) begin
                    log_mismatch($sformatf("result %0d corrected_rate got %0d expected %0d",
                                           result_count, o_corrected_rate, want.rate));
                end
            end
            result_count++;
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            kf_advance(i_measured_angle, i_measured_rate);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : run_phases
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_sample('0, '0);
        queue_sample(Q_ONE, '0);
        queue_sample(Q_MAX, Q_MAX);
        queue_sample(Q_MIN, Q_MIN);
        queue_sample(Q_MAX, Q_MIN);
        queue_sample(Q_MIN, Q_MAX);
        queue_sample(-32'sd1, 32'sd1);
        queue_sample(32'sh5555_5555, 32'shAAAA_AAAA);
        queue_sample(32'shAAAA_AAAA, 32'sh5555_5555);
        queue_sample(32'sd655360, 32'sd196608);

        wait_idle();
        load_settings('1, '1, '1, '1, 0);
        queue_sample(Q_MAX, Q_MAX);
        queue_sample(Q_MIN, Q_MIN);
        queue_sample('0, Q_MAX);
        queue_sample(Q_MIN, '0);

        // With no noise and no time step the innovation variance collapses to zero.
        wait_idle();
        load_settings('0, '0, '0, '0, 2);
        queue_sample(Q_ONE, Q_ONE);
        queue_sample(Q_MAX, -32'sd1);
        queue_sample('0, '0);
        queue_sample(Q_MIN, Q_MIN);

        // A half-unit time step turns odd rate differences into rounding ties.
        wait_idle();
        load_settings(RST_ANGLE_NOISE, RST_BIAS_NOISE, RST_MEASURE_NOISE, 16'h8000, 0);
        queue_sample(32'sd1, 32'sd1);
        queue_sample(-32'sd1, -32'sd1);
        queue_sample(32'sd3, -32'sd3);
        queue_sample(-32'sd5, 32'sd7);

        for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            case (p)
                0: load_settings(RST_ANGLE_NOISE, RST_BIAS_NOISE, RST_MEASURE_NOISE,
                                 RST_TIME_STEP, $urandom_range(0, 2));
                1: load_settings('1, '1, '1, '1, $urandom_range(0, 2));
                3: load_settings('0, '0, '0, pick_setting(), $urandom_range(0, 2));
                4: load_settings(pick_setting(), pick_setting(), pick_setting(), '1,
                                 $urandom_range(0, 2));
                default: load_settings(pick_setting(), pick_setting(), pick_setting(),
                                       pick_setting(), $urandom_range(0, 3));
            endcase
            rate_offset = int'($urandom_range(0, 262144)) - 131072;
            repeat (PHASE_SAMPLES) pending_samples.push_back(draw_sample());
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_outputs.size() != 0) begin
            log_mismatch($sformatf("%0d expected results never arrived",
                                   expected_outputs.size()));
        end
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/akf_pkg.sv
rtl/core/angle_gyro_kalman_filter.sv
tb/tb_top.sv
